### sv/dfp_pkg.sv
package dfp_pkg;

    localparam int TQ_DEPTH = 2;
    localparam int RQ_DEPTH = 2;

    localparam logic [2:0] KIND_EOI   = 3'd0;
    localparam logic [2:0] KIND_BARE  = 3'd1;
    localparam logic [2:0] KIND_QUOTE = 3'd2;
    localparam logic [2:0] KIND_LIT   = 3'd3;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_SHIFT      = 4'd1;
    localparam logic [3:0] EV_COMMAND    = 4'd2;
    localparam logic [3:0] EV_COMMENT    = 4'd3;
    localparam logic [3:0] EV_CODE       = 4'd4;
    localparam logic [3:0] EV_ARG        = 4'd5;
    localparam logic [3:0] EV_HEAD       = 4'd6;
    localparam logic [3:0] EV_BODY_START = 4'd7;
    localparam logic [3:0] EV_BODY_END   = 4'd8;
    localparam logic [3:0] EV_FINISH     = 4'd9;
    localparam logic [3:0] EV_COMMA      = 4'd10;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_TOKEN    = 3'd1;
    localparam logic [2:0] ERR_LITERAL  = 3'd2;
    localparam logic [2:0] ERR_EOI_OPEN = 3'd3;
    localparam logic [2:0] ERR_CLOSE    = 3'd4;
    localparam logic [2:0] ERR_DEPTH    = 3'd5;

    localparam logic [15:0] DEPTH_LIMIT_RESET = 16'hffff;
    localparam logic [7:0]  ARGS_MAX          = 8'hff;

    typedef enum logic [3:0] {
        C_EOI,
        C_BARE,
        C_QUOTE,
        C_HASH,
        C_PCT,
        C_LPAREN,
        C_RPAREN,
        C_COMMA,
        C_LBRACE,
        C_RBRACE,
        C_LIT_OTHER,
        C_INVALID
    } t_tok_class;

    typedef enum logic [2:0] {
        POS_TOP     = 3'd0,
        POS_NAME    = 3'd1,
        POS_ARG     = 3'd2,
        POS_ARGNEXT = 3'd3,
        POS_TAIL    = 3'd4
    } t_pos;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [2:0]  error_code;
        logic [15:0] nesting_depth;
        logic [7:0]  argument_count;
    } t_result;

    typedef struct packed {
        logic       valid;
        t_tok_class cls;
    } t_tok_xfer;

endpackage

### sv/dfp_front.sv
module dfp_front
    import dfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [2:0] i_token_kind,
    input  logic [7:0] i_literal_char,
    input  logic       i_q_ready,
    output t_tok_xfer  o_tok
);

    logic       r_valid;
    logic       n_valid;
    t_tok_class r_cls;
    t_tok_class n_cls;
    logic       accept;

    // classify the raw token
    always_comb begin
        n_cls = C_INVALID;
        case (i_token_kind)
            KIND_EOI:   n_cls = C_EOI;
            KIND_BARE:  n_cls = C_BARE;
            KIND_QUOTE: n_cls = C_QUOTE;
            KIND_LIT: begin
                case (i_literal_char)
                    CH_HASH:   n_cls = C_HASH;
                    CH_PCT:    n_cls = C_PCT;
                    CH_LPAREN: n_cls = C_LPAREN;
                    CH_RPAREN: n_cls = C_RPAREN;
                    CH_COMMA:  n_cls = C_COMMA;
                    CH_LBRACE: n_cls = C_LBRACE;
                    CH_RBRACE: n_cls = C_RBRACE;
                    default:   n_cls = C_LIT_OTHER;
                endcase
            end
            default: n_cls = C_INVALID;
        endcase
    end

    assign o_full = r_valid && !i_q_ready;
    assign accept = i_push && !o_full;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= n_cls;
        end
    end

    assign o_tok.valid = r_valid;
    assign o_tok.cls   = r_cls;

endmodule

### sv/dfp_tq.sv
module dfp_tq
    import dfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tok_xfer i_tok,
    output logic      o_ready,
    output t_tok_xfer o_tok,
    input  logic      i_take
);

    localparam int AW = $clog2(TQ_DEPTH);
    localparam int CW = $clog2(TQ_DEPTH + 1);

    t_tok_class      r_mem [TQ_DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            wr;
    logic            rd;

    assign o_ready = (r_cnt != CW'(TQ_DEPTH));
    assign wr      = i_tok.valid && o_ready;
    assign rd      = i_take && (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) begin
                r_wp <= (r_wp == AW'(TQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(TQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_tok.cls;
        end
    end

    assign o_tok.valid = (r_cnt != '0);
    assign o_tok.cls   = r_mem[r_rp];

endmodule

### sv/dfp_back.sv
module dfp_back
    import dfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  t_tok_xfer   i_tok,
    output logic        o_take,
    input  logic        i_pop,
    output logic        o_empty,
    output t_result     o_res
);

    localparam int AW = $clog2(RQ_DEPTH);
    localparam int CW = $clog2(RQ_DEPTH + 1);

    t_pos          r_pos;
    t_pos          n_pos;
    logic [15:0]   r_dep;
    logic [15:0]   n_dep;
    logic [7:0]    r_cnt;
    logic [7:0]    n_cnt;
    logic [15:0]   r_limit;
    logic [3:0]    ev;
    logic [2:0]    err;
    logic          is_lit;

    t_result       r_mem [RQ_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_ocnt;
    logic [CW-1:0] n_ocnt;
    logic          push;
    logic          pop;
    t_result       res;

    assign is_lit = i_tok.cls inside {C_HASH, C_PCT, C_LPAREN, C_RPAREN, C_COMMA,
                                      C_LBRACE, C_RBRACE, C_LIT_OTHER};

    // grammar step
    always_comb begin
        ev    = EV_NONE;
        err   = ERR_OK;
        n_pos = r_pos;
        n_dep = r_dep;
        n_cnt = r_cnt;
        case (r_pos)
            POS_NAME: begin
                if (i_tok.cls inside {C_BARE, C_QUOTE}) begin
                    ev    = EV_COMMAND;
                    n_pos = POS_TOP;
                end else if (i_tok.cls == C_LPAREN) begin
                    n_cnt = '0;
                    n_pos = POS_ARG;
                end else if (is_lit) begin
                    err = ERR_LITERAL;
                end else begin
                    err = ERR_TOKEN;
                end
            end
            POS_ARG: begin
                if (i_tok.cls inside {C_BARE, C_QUOTE}) begin
                    ev    = EV_ARG;
                    n_pos = POS_ARGNEXT;
                    if (r_cnt != ARGS_MAX) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else if (i_tok.cls == C_RPAREN) begin
                    ev    = EV_HEAD;
                    n_pos = POS_TAIL;
                end else if (is_lit) begin
                    err = ERR_LITERAL;
                end else begin
                    err = ERR_TOKEN;
                end
            end
            POS_ARGNEXT: begin
                if (i_tok.cls == C_COMMA) begin
                    ev    = EV_COMMA;
                    n_pos = POS_ARG;
                end else if (i_tok.cls == C_RPAREN) begin
                    ev    = EV_HEAD;
                    n_pos = POS_TAIL;
                end else if (is_lit) begin
                    err = ERR_LITERAL;
                end else begin
                    err = ERR_TOKEN;
                end
            end
            default: begin
                case (i_tok.cls)
                    C_EOI: begin
                        if (r_dep == '0) begin
                            ev = EV_FINISH;
                        end else begin
                            err = ERR_EOI_OPEN;
                        end
                    end
                    C_BARE: begin
                        ev    = EV_SHIFT;
                        n_pos = POS_NAME;
                    end
                    C_HASH: begin
                        ev    = EV_COMMENT;
                        n_pos = POS_TOP;
                    end
                    C_PCT: begin
                        ev    = EV_CODE;
                        n_pos = POS_TOP;
                    end
                    C_RBRACE: begin
                        if (r_dep == '0) begin
                            err = ERR_CLOSE;
                        end else begin
                            n_dep = r_dep - 1'b1;
                            ev    = EV_BODY_END;
                            n_pos = POS_TOP;
                        end
                    end
                    C_LBRACE: begin
                        if (r_pos != POS_TAIL) begin
                            err = ERR_LITERAL;
                        end else if (r_dep >= r_limit) begin
                            err = ERR_DEPTH;
                        end else begin
                            n_dep = r_dep + 1'b1;
                            ev    = EV_BODY_START;
                            n_pos = POS_TOP;
                        end
                    end
                    C_LPAREN, C_RPAREN, C_COMMA, C_LIT_OTHER: err = ERR_LITERAL;
                    default: err = ERR_TOKEN;
                endcase
            end
        endcase
        if (err != ERR_OK) begin
            ev    = EV_NONE;
            n_pos = r_pos;
            n_dep = r_dep;
            n_cnt = r_cnt;
        end
    end

    assign res.event_res      = ev;
    assign res.error_code     = err;
    assign res.nesting_depth  = n_dep;
    assign res.argument_count = n_cnt;

    assign o_take = i_tok.valid && (r_ocnt != CW'(RQ_DEPTH));
    assign push   = o_take;
    assign pop    = i_pop && !o_empty;

    always_comb begin
        n_ocnt = r_ocnt;
        if (push && !pop) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (pop && !push) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_TOP;
            r_dep   <= '0;
            r_cnt   <= '0;
            r_limit <= DEPTH_LIMIT_RESET;
            r_wp    <= '0;
            r_rp    <= '0;
            r_ocnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (push) begin
                r_pos <= n_pos;
                r_dep <= n_dep;
                r_cnt <= n_cnt;
                r_wp  <= (r_wp == AW'(RQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(RQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= res;
        end
    end

    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_mem[r_rp];

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= CW'(RQ_DEPTH))
        else $error("result queue overfilled");

    a_err_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && (err != ERR_OK) |=>
        (r_pos == $past(r_pos)) && (r_dep == $past(r_dep)) && (r_cnt == $past(r_cnt)))
        else $error("state changed on error");

    a_err_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && (err != ERR_OK) |-> (ev == EV_NONE))
        else $error("event with error");

    a_body_start_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && (ev == EV_BODY_START) |=> (r_dep == 16'($past(r_dep) + 16'd1)))
        else $error("depth not incremented on body start");

endmodule

### sv/definition_file_token_parser_unit.sv
// channel  | handshake          | transfer when          | payload
// token    | i_push / o_full    | i_push && !o_full      | i_token_kind, i_literal_char
// result   | o_empty / i_pop    | i_pop && !o_empty      | o_event_res, o_error_code,
//          |                    |                        | o_nesting_depth, o_argument_count
// config   | i_cfg_valid / o_cfg_ready | both high       | i_cfg_data (depth_limit)
//
// one token per cycle sustained while results are popped; a token's result passes
// through the classify register, token queue and grammar step into the result queue
// the grammar state update is a registered loop in the back end
// synchronous active-low reset empties both queues, depth_limit resets to 65535
// a stalled result side fills the 2-entry result queue, then the token queue, then full rises
module definition_file_token_parser_unit
    import dfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_token_kind,
    input  logic [7:0]  i_literal_char,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [3:0]  o_event_res,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_nesting_depth,
    output logic [7:0]  o_argument_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_tok_xfer front_tok;
    t_tok_xfer q_tok;
    logic      q_ready;
    logic      take;
    t_result   res;

    dfp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_token_kind   (i_token_kind),
        .i_literal_char (i_literal_char),
        .i_q_ready      (q_ready),
        .o_tok          (front_tok)
    );

    dfp_tq u_tq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (front_tok),
        .o_ready (q_ready),
        .o_tok   (q_tok),
        .i_take  (take)
    );

    dfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_tok       (q_tok),
        .o_take      (take),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (res)
    );

    assign o_cfg_ready      = 1'b1;
    assign o_event_res      = res.event_res;
    assign o_error_code     = res.error_code;
    assign o_nesting_depth  = res.nesting_depth;
    assign o_argument_count = res.argument_count;

endmodule
